>>> hdl/ogru_pkg.sv
`timescale 1ns / 1ps

package ogru_pkg;

   // grid geometry
   localparam int GRID_WIDTH  = 256;
   localparam int GRID_HEIGHT = 256;
   localparam int GRID_DEPTH  = GRID_WIDTH * GRID_HEIGHT;
   localparam int ADDR_W      = $clog2(GRID_DEPTH);

   // field widths
   localparam int COORD_W   = 11;
   localparam int CELL_W    = 8;
   localparam int STEP_W    = 7;
   localparam int COUNT_W   = 11;
   localparam int DELTA_W   = 11;   // |x1 - x0| stays below 2048
   localparam int ERR_W     = 14;
   localparam int SUM_W     = 10;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic signed [CELL_W-1:0] CELL_MAX = 8'sd127;
   localparam logic signed [CELL_W-1:0] CELL_MIN = -8'sd127;

   // register index, taken from paddr bit 2
   localparam logic CSR_IDX_HIT  = 1'b0;
   localparam logic CSR_IDX_MISS = 1'b1;

   localparam logic [STEP_W-1:0] HIT_STEP_RST  = 7'd3;
   localparam logic [STEP_W-1:0] MISS_STEP_RST = 7'd1;

   typedef enum logic [1:0] {
      MODE_HIT  = 2'd0,
      MODE_RAY  = 2'd1,
      MODE_READ = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK,
      ST_SINGLE,
      ST_DRAIN
   } state_type;

   typedef enum logic [1:0] {
      OP_HIT,
      OP_MISS,
      OP_READ
   } op_type;

   function automatic logic on_grid(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y);
      int xi;
      int yi;
      xi = int'(x);
      yi = int'(y);
      return (xi >= 0) && (xi < GRID_WIDTH) && (yi >= 0) && (yi < GRID_HEIGHT);
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [COORD_W-1:0] x,
                                                    input logic signed [COORD_W-1:0] y);
      int a;
      a = int'($unsigned(y)) * GRID_WIDTH + int'($unsigned(x));
      return ADDR_W'(a);
   endfunction

endpackage

>>> hdl/ogru_ram.sv
`timescale 1ns / 1ps

module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/occupancy_grid_ray_update_top.sv
`timescale 1ns / 1ps

// Occupancy grid ray update.
// req_ channel: one word per command. tuser holds the mode (0 score endpoint,
// 1 trace free ray, 2 read cell, 3 no-op); tdata holds the start and end cells.
// rsp_ channel: exactly one word per command with the read cell value (zero
// unless mode 2) and the number of in-grid cells written.
// csr_ port: hit_step at 0x0, miss_step at 0x4; write only while idle.
// Timing: one read port and one write port on the grid memory are the limit;
// one line cell is read, updated and written back per cycle, pipelined.
// Mode 1 walks the line (ST_WALK), modes 0 and 2 touch one cell (ST_SINGLE) and
// mode 3 goes straight to ST_DRAIN, which loads the result register. One command
// is in flight at a time; req_tready is high only while idle.
// Reset: the grid is cleared by a pass over all GRID_DEPTH cells, during
// which no command is taken; config writes still work.
// Stall: the result sits in an output register; a new command is accepted
// while it waits, but that command stops before its own result until the
// previous word is taken.
module occupancy_grid_ray_update_top
   import ogru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // slave stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // start_x, start_y, end_x, end_y, zero pad
   input  logic [1:0]            req_tuser,  // mode
   // master stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // cell_value, cells_changed, zero pad
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   // ---------------- registers ----------------
   logic [STEP_W-1:0] hit_step_ff, hit_step_in;
   logic [STEP_W-1:0] miss_step_ff, miss_step_in;
   logic              csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      hit_step_in  = hit_step_ff;
      miss_step_in = miss_step_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            CSR_IDX_HIT:  hit_step_in  = csr_pwdata[STEP_W-1:0];
            CSR_IDX_MISS: miss_step_in = csr_pwdata[STEP_W-1:0];
            default:      hit_step_in  = hit_step_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_IDX_HIT:  csr_prdata = CSR_DATA_W'(hit_step_ff);
         CSR_IDX_MISS: csr_prdata = CSR_DATA_W'(miss_step_ff);
         default:      csr_prdata = '0;
      endcase
   end

   // ---------------- input unpack ----------------
   logic signed [COORD_W-1:0] in_x0, in_y0, in_x1, in_y1;
   logic signed [DELTA_W:0]   in_dxs, in_dys;
   logic [DELTA_W-1:0]        in_dx, in_dy;
   logic                      req_acc;

   assign in_x0  = req_tdata[COORD_W-1:0];
   assign in_y0  = req_tdata[2*COORD_W-1:COORD_W];
   assign in_x1  = req_tdata[3*COORD_W-1:2*COORD_W];
   assign in_y1  = req_tdata[4*COORD_W-1:3*COORD_W];
   assign in_dxs = (DELTA_W+1)'(in_x1) - (DELTA_W+1)'(in_x0);
   assign in_dys = (DELTA_W+1)'(in_y1) - (DELTA_W+1)'(in_y0);
   assign in_dx  = in_dxs[DELTA_W] ? DELTA_W'(-in_dxs) : DELTA_W'(in_dxs);
   assign in_dy  = in_dys[DELTA_W] ? DELTA_W'(-in_dys) : DELTA_W'(in_dys);

   // ---------------- sequencer state ----------------
   state_type                 state_ff, state_in;
   logic [ADDR_W-1:0]         clr_addr_ff, clr_addr_in;
   mode_type                  mode_ff, mode_in;
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [DELTA_W-1:0]        dx_ff, dx_in, dy_ff, dy_in;
   logic                      sx_neg_ff, sx_neg_in, sy_neg_ff, sy_neg_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;

   // read-modify-write stage
   logic                      p1_valid_ff, p1_valid_in;
   op_type                    p1_kind_ff, p1_kind_in;
   logic [ADDR_W-1:0]         p1_addr_ff, p1_addr_in;

   // per-command accumulators and result register
   logic signed [CELL_W-1:0]  value_ff, value_in;
   logic [COUNT_W-1:0]        changed_ff, changed_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [CELL_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [COUNT_W-1:0]        rsp_changed_ff, rsp_changed_in;

   // datapath controls
   logic signed [COORD_W-1:0] cur_x, cur_y;
   logic                      cur_on, at_end, out_free;
   logic                      issue, step_en;
   op_type                    issue_kind;
   logic                      ram_we, ram_re;
   logic [ADDR_W-1:0]         ram_waddr, ram_raddr;
   logic [CELL_W-1:0]         ram_wdata, ram_rdata;
   logic signed [SUM_W-1:0]   sum, diff;
   logic signed [CELL_W-1:0]  upd_value;
   logic signed [ERR_W:0]     e2;
   logic                      step_x, step_y;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid & req_tready;
   assign at_end     = (cx_ff == ex_ff) && (cy_ff == ey_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(GRID_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               unique case (mode_type'(req_tuser))
                  MODE_RAY:  state_in = ST_WALK;
                  MODE_HIT:  state_in = ST_SINGLE;
                  MODE_READ: state_in = ST_SINGLE;
                  MODE_NONE: state_in = ST_DRAIN;
                  default:   state_in = ST_DRAIN;
               endcase
            end
         end
         ST_WALK: begin
            if (at_end) begin
               state_in = ST_DRAIN;
            end
         end
         ST_SINGLE: state_in = ST_DRAIN;
         ST_DRAIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      cur_x      = cx_ff;
      cur_y      = cy_ff;
      issue      = 1'b0;
      issue_kind = OP_MISS;
      step_en    = 1'b0;
      if (state_ff == ST_SINGLE && mode_ff == MODE_HIT) begin
         cur_x = ex_ff;
         cur_y = ey_ff;
      end
      cur_on = on_grid(cur_x, cur_y);
      unique case (state_ff)
         ST_WALK: begin
            step_en    = !at_end;
            issue      = !at_end && cur_on;
            issue_kind = OP_MISS;
         end
         ST_SINGLE: begin
            unique case (mode_ff)
               MODE_HIT: begin
                  issue      = cur_on;
                  issue_kind = OP_HIT;
               end
               MODE_READ: begin
                  issue      = cur_on;
                  issue_kind = OP_READ;
               end
               default: issue = 1'b0;
            endcase
         end
         default: issue = 1'b0;
      endcase
   end

   // Bresenham step
   always_comb begin
      e2     = {err_ff, 1'b0};
      step_x = e2 >= -$signed((ERR_W+1)'(dy_ff));
      step_y = e2 <= $signed((ERR_W+1)'(dx_ff));
      cx_in  = cx_ff;
      cy_in  = cy_ff;
      ex_in  = ex_ff;
      ey_in  = ey_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      sx_neg_in = sx_neg_ff;
      sy_neg_in = sy_neg_ff;
      err_in = err_ff;
      mode_in = mode_ff;
      if (req_acc) begin
         mode_in   = mode_type'(req_tuser);
         cx_in     = in_x0;
         cy_in     = in_y0;
         ex_in     = in_x1;
         ey_in     = in_y1;
         dx_in     = in_dx;
         dy_in     = in_dy;
         sx_neg_in = !(in_x0 < in_x1);
         sy_neg_in = !(in_y0 < in_y1);
         err_in    = $signed(ERR_W'(in_dx)) - $signed(ERR_W'(in_dy));
      end else if (step_en) begin
         if (step_x) begin
            cx_in = cx_ff + (sx_neg_ff ? -11'sd1 : 11'sd1);
         end
         if (step_y) begin
            cy_in = cy_ff + (sy_neg_ff ? -11'sd1 : 11'sd1);
         end
         err_in = err_ff - (step_x ? $signed(ERR_W'(dy_ff)) : '0)
                         + (step_y ? $signed(ERR_W'(dx_ff)) : '0);
      end
   end

   // read-modify-write: read issued now, updated and written in the next cycle
   assign p1_valid_in = issue;
   assign p1_kind_in  = issue_kind;
   assign p1_addr_in  = cell_addr(cur_x, cur_y);
   assign ram_re      = issue;
   assign ram_raddr   = p1_addr_in;

   always_comb begin
      sum  = SUM_W'($signed(ram_rdata)) + $signed(SUM_W'(hit_step_ff));
      diff = SUM_W'($signed(ram_rdata)) - $signed(SUM_W'(miss_step_ff));
      if (p1_kind_ff == OP_HIT) begin
         upd_value = (sum < SUM_W'(CELL_MAX)) ? CELL_W'(sum) : CELL_MAX;
      end else begin
         upd_value = (diff > SUM_W'(CELL_MIN)) ? CELL_W'(diff) : CELL_MIN;
      end
   end

   always_comb begin
      ram_we      = 1'b0;
      ram_waddr   = p1_addr_ff;
      ram_wdata   = upd_value;
      clr_addr_in = clr_addr_ff;
      value_in    = value_ff;
      changed_in  = changed_ff;
      if (state_ff == ST_CLEAR) begin
         ram_we      = 1'b1;
         ram_waddr   = clr_addr_ff;
         ram_wdata   = '0;
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
      end else if (req_acc) begin
         value_in   = '0;
         changed_in = '0;
      end else if (p1_valid_ff) begin
         if (p1_kind_ff == OP_READ) begin
            value_in = ram_rdata;
         end else begin
            ram_we     = 1'b1;
            changed_in = changed_ff + COUNT_W'(1);
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_changed_in = rsp_changed_ff;
      if (state_ff == ST_DRAIN && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_value_in   = value_in;
         rsp_changed_in = changed_in;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - CELL_W - COUNT_W){1'b0}}, rsp_changed_ff, rsp_value_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         hit_step_ff  <= HIT_STEP_RST;
         miss_step_ff <= MISS_STEP_RST;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         hit_step_ff  <= hit_step_in;
         miss_step_ff <= miss_step_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      sx_neg_ff      <= sx_neg_in;
      sy_neg_ff      <= sy_neg_in;
      err_ff         <= err_in;
      p1_kind_ff     <= p1_kind_in;
      p1_addr_ff     <= p1_addr_in;
      value_ff       <= value_in;
      changed_ff     <= changed_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   ogru_ram #(
      .WIDTH (CELL_W),
      .DEPTH (GRID_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------- assertions ----------------
   // no update may still be in flight once the block reports idle
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !p1_valid_ff)
      else $error("pending grid write while idle");

   // a cell read in the same cycle as a write must not be the written cell
   a_no_rmw_hazard: assert property (@(posedge clock) disable iff (reset)
      (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
      else $error("read of a cell that is being written");

   // grid writes come only from the clear pass or a hit/miss update
   a_write_source: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_CLEAR) ||
                  (p1_valid_ff && (p1_kind_ff == OP_HIT || p1_kind_ff == OP_MISS))))
      else $error("unexpected grid write");

   // a walk that issued a read in consecutive cycles moved to a new cell
   a_walk_moves: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK && ram_re && $past(state_ff == ST_WALK) && $past(ram_re))
      |-> (ram_raddr != $past(ram_raddr)))
      else $error("line walk did not advance");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import ogru_pkg::*;

   typedef struct packed {
      mode_type           mode;
      logic [COORD_W-1:0] sx;
      logic [COORD_W-1:0] sy;
      logic [COORD_W-1:0] ex;
      logic [COORD_W-1:0] ey;
   } req_word_type;

   typedef struct packed {
      logic [CELL_W-1:0]  value;
      logic [COUNT_W-1:0] changed;
   } rsp_word_type;

   typedef struct packed {
      logic              is_cfg;
      logic              reg_idx;
      logic [STEP_W-1:0] reg_val;
      logic              typed;
      req_word_type      word;
      rsp_word_type      want;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;  // start_x, start_y, end_x, end_y, zero pad
   logic [1:0]            req_tuser = '0;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // cell_value, cells_changed, zero pad
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // shadow copy of the grid and the step registers
   logic signed [CELL_W-1:0] occ_grid [GRID_DEPTH];
   int           hit_now = int'(HIT_STEP_RST);
   int           miss_now = int'(MISS_STEP_RST);
   rsp_word_type pending_rsp [$];
   rsp_word_type oldest;
   plan_row_type plan [$];
   int           mismatches = 0;
   int           rx_hold = 0;
   bit           no_idle = 1'b0;

   occupancy_grid_ray_update_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic bit in_bounds(input int x, input int y);
      return x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT;
   endfunction

   function automatic void add_row(input plan_row_type p);
      plan = {plan, p};
   endfunction

   // updates the shadow grid and returns the word the block should send
   function automatic rsp_word_type apply_to_grid(input req_word_type w);
      rsp_word_type r;
      int x0, y0, x1, y1, dx, dy, sx, sy, err, e2, cx, cy, v, cnt;
      r = '0;
      cnt = 0;
      x0 = int'($signed(w.sx));
      y0 = int'($signed(w.sy));
      x1 = int'($signed(w.ex));
      y1 = int'($signed(w.ey));
      case (w.mode)
         MODE_HIT: begin
            if (in_bounds(x1, y1)) begin
               v = int'(occ_grid[y1 * GRID_WIDTH + x1]) + hit_now;
               occ_grid[y1 * GRID_WIDTH + x1] = (v < int'(CELL_MAX)) ? CELL_W'(v) : CELL_MAX;
               cnt = 1;
            end
         end
         MODE_RAY: begin
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = (y1 > y0) ? y1 - y0 : y0 - y1;
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx - dy;
            cx = x0;
            cy = y0;
            while (cx != x1 || cy != y1) begin
               e2 = 2 * err;
               if (in_bounds(cx, cy)) begin
                  v = int'(occ_grid[cy * GRID_WIDTH + cx]) - miss_now;
                  occ_grid[cy * GRID_WIDTH + cx] =
                     (v > int'(CELL_MIN)) ? CELL_W'(v) : CELL_MIN;
                  cnt++;
               end
               if (e2 >= -dy) begin
                  err -= dy;
                  cx += sx;
               end
               if (e2 <= dx) begin
                  err += dx;
                  cy += sy;
               end
            end
         end
         MODE_READ: begin
            if (in_bounds(x0, y0))
               r.value = occ_grid[y0 * GRID_WIDTH + x0];
         end
         default: ;
      endcase
      r.changed = COUNT_W'(cnt);
      return r;
   endfunction

   function automatic plan_row_type step_row(input mode_type m, input int x0, input int y0,
                                             input int x1, input int y1);
      plan_row_type p;
      p = '0;
      p.word.mode = m;
      p.word.sx = COORD_W'(x0);
      p.word.sy = COORD_W'(y0);
      p.word.ex = COORD_W'(x1);
      p.word.ey = COORD_W'(y1);
      return p;
   endfunction

   function automatic plan_row_type known_row(input mode_type m, input int x0, input int y0,
                                              input int x1, input int y1,
                                              input int v, input int c);
      plan_row_type p;
      p = step_row(m, x0, y0, x1, y1);
      p.typed = 1'b1;
      p.want.value = CELL_W'(v);
      p.want.changed = COUNT_W'(c);
      return p;
   endfunction

   function automatic plan_row_type cfg_row(input logic idx, input int val);
      plan_row_type p;
      p = '0;
      p.is_cfg = 1'b1;
      p.reg_idx = idx;
      p.reg_val = STEP_W'(val);
      return p;
   endfunction

   function automatic int pause_len();
      int p;
      p = $urandom_range(0, 99);
      if (no_idle || p < 60)
         return 0;
      if (p < 90)
         return span(1, 3);
      if (p < 97)
         return span(4, 12);
      return span(20, 150);
   endfunction

   // mostly a small patch so cells pile up and saturate, some edge and long rays
   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      int x0, y0;
      pick = $urandom_range(0, 99);
      w.mode = (pick < 35) ? MODE_HIT : (pick < 70) ? MODE_RAY :
               (pick < 95) ? MODE_READ : MODE_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         w.sx = COORD_W'(span(0, 15));
         w.sy = COORD_W'(span(0, 15));
         w.ex = COORD_W'(span(0, 15));
         w.ey = COORD_W'(span(0, 15));
      end else if (pick < 80) begin
         w.sx = COORD_W'(span(-8, GRID_WIDTH + 7));
         w.sy = COORD_W'(span(-8, GRID_HEIGHT + 7));
         w.ex = COORD_W'(span(-8, GRID_WIDTH + 7));
         w.ey = COORD_W'(span(-8, GRID_HEIGHT + 7));
      end else if (pick < 95) begin
         x0 = span(0, GRID_WIDTH - 1);
         y0 = span(0, GRID_HEIGHT - 1);
         w.sx = COORD_W'(x0);
         w.sy = COORD_W'(y0);
         w.ex = COORD_W'(x0 + span(-40, 40));
         w.ey = COORD_W'(y0 + span(-40, 40));
      end else begin
         w.sx = COORD_W'($urandom);
         w.sy = COORD_W'($urandom);
         w.ex = COORD_W'($urandom);
         w.ey = COORD_W'($urandom);
      end
      return w;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
   endtask

   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type want);
      int gap;
      rsp_word_type r;
      gap = pause_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - 4 * COORD_W){1'b0}}, w.ey, w.ex, w.sy, w.sx};
      req_tuser <= w.mode;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      r = apply_to_grid(w);
      pending_rsp = {pending_rsp, (typed ? want : r)};
   endtask

   // drops valid first and always waits on the clock, so the next valid never collides
   task automatic wait_all_back();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0)
         @(posedge clock);
   endtask

   // write, then read back; upper data bits are junk and must be dropped
   task automatic csr_update(input logic idx, input logic [STEP_W-1:0] val);
      logic [CSR_DATA_W-1:0] got;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= ($urandom & ~CSR_DATA_W'(7'h7f)) | CSR_DATA_W'(val);
      csr_pwrite <= 1'b1;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == CSR_IDX_HIT)
         hit_now = int'(val);
      else
         miss_now = int'(val);
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      got = csr_prdata;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      if (got !== CSR_DATA_W'(val))
         report_mismatch(idx == CSR_IDX_HIT ? "hit_step readback" : "miss_step readback",
                         int'(val), int'(got));
   endtask

   always @(posedge clock) begin
      if (rx_hold > 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (!no_idle && $urandom_range(0, 4) == 0)
            rx_hold <= pause_len();
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected word, cells_changed", -1, int'(rsp_tdata[18:8]));
         end else begin
            oldest = pending_rsp.pop_front();
            if (rsp_tdata[7:0] !== oldest.value)
               report_mismatch("cell_value", int'($signed(oldest.value)),
                               int'($signed(rsp_tdata[7:0])));
            if (rsp_tdata[18:8] !== oldest.changed)
               report_mismatch("cells_changed", int'(oldest.changed), int'(rsp_tdata[18:8]));
            if (rsp_tdata[RSP_DATA_W-1:19] !== '0)
               report_mismatch("rsp pad", 0, int'(rsp_tdata[RSP_DATA_W-1:19]));
         end
      end
   end

   initial begin
      plan_row_type row;
      int hit_val;
      int miss_val;
      for (int i = 0; i < GRID_DEPTH; i++)
         occ_grid[i] = '0;

      // default steps: hit 3, miss 1
      add_row(known_row(MODE_READ, 0, 0, 0, 0, 0, 0));
      add_row(known_row(MODE_READ, 255, 255, 0, 0, 0, 0));
      add_row(known_row(MODE_HIT, 0, 0, 0, 0, 0, 1));
      add_row(known_row(MODE_READ, 0, 0, 0, 0, 3, 0));
      add_row(known_row(MODE_HIT, 9, 9, 255, 255, 0, 1));
      add_row(known_row(MODE_HIT, 0, 0, -1, 5, 0, 0));
      add_row(known_row(MODE_HIT, 0, 0, 256, 0, 0, 0));
      add_row(known_row(MODE_HIT, 0, 0, -1024, -1024, 0, 0));
      add_row(known_row(MODE_HIT, 0, 0, 1023, 1023, 0, 0));
      add_row(known_row(MODE_RAY, 10, 10, 10, 10, 0, 0));
      add_row(step_row(MODE_RAY, 0, 0, 5, 0));
      add_row(step_row(MODE_READ, 0, 0, 0, 0));
      add_row(known_row(MODE_RAY, -1024, -1024, 1023, -1024, 0, 0));
      add_row(step_row(MODE_RAY, -1024, -1024, 1023, 1023));
      add_row(step_row(MODE_RAY, 1023, 1023, -1024, -1024));
      add_row(step_row(MODE_RAY, 3, 0, 4, 200));
      add_row(step_row(MODE_RAY, 255, 0, 0, 255));
      add_row(known_row(MODE_NONE, 1, 1, 2, 2, 0, 0));
      add_row(known_row(MODE_READ, -1, 0, 5, 5, 0, 0));
      add_row(known_row(MODE_READ, 256, 3, 0, 0, 0, 0));
      // largest steps: one hit saturates, one miss saturates
      add_row(cfg_row(CSR_IDX_HIT, 127));
      add_row(cfg_row(CSR_IDX_MISS, 127));
      add_row(known_row(MODE_HIT, 0, 0, 7, 7, 0, 1));
      add_row(known_row(MODE_HIT, 0, 0, 7, 7, 0, 1));
      add_row(known_row(MODE_READ, 7, 7, 0, 0, 127, 0));
      add_row(step_row(MODE_RAY, 7, 7, 7, 9));
      add_row(step_row(MODE_RAY, 7, 8, 7, 10));
      add_row(known_row(MODE_READ, 7, 8, 0, 0, -127, 0));
      add_row(cfg_row(CSR_IDX_HIT, 0));
      add_row(cfg_row(CSR_IDX_MISS, 0));
      add_row(step_row(MODE_HIT, 0, 0, 7, 8));
      add_row(step_row(MODE_RAY, 7, 9, 7, 7));
      add_row(known_row(MODE_READ, 7, 8, 0, 0, -127, 0));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.is_cfg) begin
            wait_all_back();
            csr_update(row.reg_idx, row.reg_val);
         end else begin
            send_word(row.word, row.typed, row.want);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         hit_val = (phase == 0) ? 127 : (phase == 1) ? 0 : (phase == 3) ? 1 : span(0, 127);
         miss_val = (phase == 0) ? 0 : (phase == 1) ? 127 : (phase == 3) ? 1 : span(0, 127);
         wait_all_back();
         csr_update(CSR_IDX_HIT, STEP_W'(hit_val));
         csr_update(CSR_IDX_MISS, STEP_W'(miss_val));
         no_idle = (phase == 3);
         for (int n = 0; n < 308; n++) begin
            if ($urandom_range(0, 199) == 0)
               wait_all_back();
            send_word(random_word(), 1'b0, '0);
         end
      end

      wait_all_back();
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #100_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
